/* rtl/core/kct_pkg.sv */
// Shared types and constants for the keyed counter table.
`timescale 1ns / 1ps
`default_nettype none
package kct_pkg;

	localparam int KEY_W = 32;
	localparam int CNT_W = 31;
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_GET   = 2'd1,
		OP_SET   = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} rsp_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_UPDATE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture the incoming transaction
		logic issue;   // read the entry at the scan pointer
		logic commit;  // apply the update and load the result register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_clear;   // incoming transaction is a clear
		logic last_addr;  // scan pointer is at the last entry
		logic out_free;   // result register can take a new result
	} ctrl_sts_t;

endpackage
`default_nettype wire

/* rtl/core/kct_if.sv */
// Request and response channel interfaces of the keyed counter table.
`timescale 1ns / 1ps
`default_nettype none
interface kct_in_if import kct_pkg::*; ();
	logic                    valid;
	logic                    ready;
	op_t                     op;
	logic signed [KEY_W-1:0] key;
	logic signed [KEY_W-1:0] value;

	modport source(output valid, op, key, value, input ready);
	modport sink(input valid, op, key, value, output ready);
endinterface

interface kct_out_if import kct_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] count;
	logic             found;
	rsp_status_t      status;

	modport source(output valid, count, found, status, input ready);
	modport sink(input valid, count, found, status, output ready);
endinterface
`default_nettype wire

/* rtl/core/keyed_counter_table_unit.sv */
// Keyed counter table: top level joining controller, datapath and channels.
`timescale 1ns / 1ps
`default_nettype none
// Holds up to ENTRIES key/counter pairs. Each request transaction is add,
// get, set or clear and yields exactly one response transaction. Lookups
// walk the key and count RAMs one entry per cycle through a single
// comparator. A non-clear request passes through an accept state, one RAM
// read per entry, a compare drain state and an update state, where its
// response is registered. Clear goes from accept straight to update. A
// finished response sits in an output register, and the next request is
// accepted while it waits; an update waits only if the previous response is
// still unclaimed. Counters saturate at 2^31-1, a set with a value of zero
// or below leaves the table untouched, and an insert into a full table
// reports full and changes nothing.
module keyed_counter_table_unit import kct_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	kct_in_if.sink    req,
	kct_out_if.source rsp
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	kct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kct_datapath #(.ENTRIES(ENTRIES)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_op      (req.op),
		.in_key     (req.key),
		.in_value   (req.value),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_count  (rsp.count),
		.out_found  (rsp.found),
		.out_status (rsp.status)
	);

	// every accepted transaction is captured by the datapath
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> cmd.load)
		else $error("accepted request not captured");

	// no new request while the table is being scanned
	a_scan_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !req.ready)
		else $error("request accepted during scan");

	// a commit always produces a response next cycle
	a_commit_responds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp.valid)
		else $error("commit without response");

	// a commit never overwrites an unclaimed response
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!rsp.valid || rsp.ready))
		else $error("response overwritten");

endmodule
`default_nettype wire

/* rtl/core/kct_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module kct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/kct_ctrl.sv */
// Sequencing state machine: accept, scan, compare drain, update.
`timescale 1ns / 1ps
`default_nettype none
module kct_ctrl import kct_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire ctrl_sts_t sts,
	output ctrl_cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					// clear needs no lookup
					state_d  = sts.is_clear ? S_UPDATE : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.last_addr) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_UPDATE;
			end
			S_UPDATE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/kct_datapath.sv */
// Key/count stores, scan compare stage, update logic and result register.
`timescale 1ns / 1ps
`default_nettype none
module kct_datapath import kct_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire op_t                     in_op,
	input  wire logic signed [KEY_W-1:0] in_key,
	input  wire logic signed [KEY_W-1:0] in_value,
	input  wire ctrl_cmd_t               cmd,
	output ctrl_sts_t                    sts,
	input  wire logic                    out_ready,
	output logic                         out_valid,
	output logic [CNT_W-1:0]             out_count,
	output logic                         out_found,
	output rsp_status_t                  out_status
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	// captured transaction
	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] value_q;

	// table state
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0]      fill_q;

	// scan pointer and compare stage
	logic [CW-1:0]    scan_q;
	logic             hit_v_s1;
	logic [IW-1:0]    idx_s1;
	logic             vld_s1;
	logic [KEY_W-1:0] key_rd;
	logic [CNT_W-1:0] cnt_rd;

	// lookup outcome
	logic             found_q;
	logic [IW-1:0]    match_idx_q;
	logic [CNT_W-1:0] match_cnt_q;
	logic             free_found_q;
	logic [IW-1:0]    free_idx_q;

	// update decode
	logic             full;
	logic             positive;
	logic [CNT_W-1:0] inc_cnt;
	logic             do_ins;
	logic             do_upd;
	logic             do_clr;
	logic [CNT_W-1:0] wr_cnt;
	logic [CNT_W-1:0] res_cnt;
	rsp_status_t      res_status;
	logic [IW-1:0]    wr_idx;
	logic             key_hit;
	logic             free_hit;

	assign sts.is_clear  = (in_op == OP_CLEAR);
	assign sts.last_addr = (scan_q == CW'(ENTRIES - 1));
	assign sts.out_free  = !out_valid || out_ready;

	kct_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (cmd.commit && do_ins),
		.waddr (wr_idx),
		.wdata (key_q),
		.re    (cmd.issue),
		.raddr (scan_q[IW-1:0]),
		.rdata (key_rd)
	);

	kct_ram #(.WIDTH(CNT_W), .DEPTH(ENTRIES)) u_cnt_ram (
		.clk   (clk),
		.we    (cmd.commit && (do_ins || do_upd)),
		.waddr (wr_idx),
		.wdata (wr_cnt),
		.re    (cmd.issue),
		.raddr (scan_q[IW-1:0]),
		.rdata (cnt_rd)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_op;
			key_q   <= in_key;
			value_q <= in_value;
		end
		if (cmd.issue) begin
			idx_s1 <= scan_q[IW-1:0];
			vld_s1 <= valid_q[scan_q[IW-1:0]];
		end
	end

	assign key_hit  = hit_v_s1 && vld_s1 && (key_rd == key_q);
	assign free_hit = hit_v_s1 && !vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			hit_v_s1     <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (cmd.load) begin
			scan_q       <= '0;
			hit_v_s1     <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			hit_v_s1 <= cmd.issue;
			if (cmd.issue) begin
				scan_q <= scan_q + CW'(1);
			end
			// keep the first match and the lowest free slot
			if (key_hit && !found_q) begin
				found_q <= 1'b1;
			end
			if (free_hit && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_hit && !found_q) begin
			match_idx_q <= idx_s1;
			match_cnt_q <= cnt_rd;
		end
		if (free_hit && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
	end

	assign full     = (fill_q == CW'(ENTRIES));
	assign positive = !value_q[KEY_W-1] && (value_q != '0);
	assign inc_cnt  = (match_cnt_q == COUNT_MAX) ? COUNT_MAX : match_cnt_q + CNT_W'(1);
	assign wr_idx   = do_ins ? free_idx_q : match_idx_q;

	always_comb begin
		do_ins     = 1'b0;
		do_upd     = 1'b0;
		do_clr     = 1'b0;
		wr_cnt     = '0;
		res_cnt    = '0;
		res_status = ST_OK;
		case (op_q)
			OP_CLEAR: begin
				do_clr = 1'b1;
			end
			OP_GET: begin
				if (found_q) begin
					res_cnt = match_cnt_q;
				end
			end
			OP_ADD: begin
				if (found_q) begin
					do_upd  = 1'b1;
					wr_cnt  = inc_cnt;
					res_cnt = inc_cnt;
				end else if (!full) begin
					do_ins  = 1'b1;
					wr_cnt  = CNT_W'(1);
					res_cnt = CNT_W'(1);
				end else begin
					res_status = ST_FULL;
				end
			end
			OP_SET: begin
				if (!positive) begin
					res_status = ST_IGNORED;
					if (found_q) begin
						res_cnt = match_cnt_q;
					end
				end else if (found_q) begin
					do_upd  = 1'b1;
					wr_cnt  = value_q[CNT_W-1:0];
					res_cnt = value_q[CNT_W-1:0];
				end else if (!full) begin
					do_ins  = 1'b1;
					wr_cnt  = value_q[CNT_W-1:0];
					res_cnt = value_q[CNT_W-1:0];
				end else begin
					res_status = ST_FULL;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
		end else if (cmd.commit) begin
			if (do_clr) begin
				valid_q <= '0;
				fill_q  <= '0;
			end else if (do_ins) begin
				valid_q[free_idx_q] <= 1'b1;
				fill_q              <= fill_q + CW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.commit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_count  <= res_cnt;
			out_found  <= found_q;
			out_status <= res_status;
		end
	end

endmodule
`default_nettype wire
